// ===== hdl/gda_pkg.sv =====
// Package for the Gregorian date adder: payload structs, widths and
// cumulative month tables. No dependencies.
`timescale 1ns / 1ps
package gda_pkg;

   localparam int YEAR_W   = 16;
   localparam int OFFSET_W = 24;
   localparam int SER_W    = 27;
   localparam int EY_W     = 20;

   typedef struct packed {
      logic [OFFSET_W-1:0] offset_days;
      logic [4:0]          start_day;
      logic [3:0]          start_month;
      logic [YEAR_W-1:0]   start_year;
   } req_type;

   typedef struct packed {
      logic [4:0]        end_day;
      logic [3:0]        end_month;
      logic [YEAR_W-1:0] end_year;
      logic              overflow;
   } rsp_type;

   localparam logic [8:0] CUM_LEAP [0:12] =
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244,
        9'd274, 9'd305, 9'd335, 9'd366};
   localparam logic [8:0] CUM_COMMON [0:12] =
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243,
        9'd273, 9'd304, 9'd334, 9'd365};

endpackage

// ===== hdl/gda_front.sv =====
// Front stage: takes requests, normalizes day, month and year, holds one
// request for the queue. Depends on gda_pkg.
`timescale 1ns / 1ps
module gda_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gda_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_full,
   output gda_pkg::req_type push_data
);

   logic             valid_ff, valid_in;
   gda_pkg::req_type item_ff, norm;
   logic             take;

   always_comb begin
      norm = req_data;
      if (req_data.start_day == 5'd0) norm.start_day = 5'd1;
      if (req_data.start_month == 4'd0) norm.start_month = 4'd1;
      if (req_data.start_month > 4'd12) norm.start_month = 4'd12;
      if (req_data.start_year == '0) norm.start_year = gda_pkg::YEAR_W'(1);
   end

   assign req_stall  = valid_ff & push_full;
   assign take       = req_valid & ~req_stall;
   assign valid_in   = take | (valid_ff & push_full);
   assign push_valid = valid_ff;
   assign push_data  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= norm;
      end
   end

endmodule

// ===== hdl/gda_queue.sv =====
// Two-entry queue between front and back stages. Depends on gda_pkg.
`timescale 1ns / 1ps
module gda_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_full,
   input  gda_pkg::req_type push_data,
   output logic             pop_valid,
   input  logic             pop_take,
   output gda_pkg::req_type pop_data
);

   gda_pkg::req_type mem_ff [0:1];
   logic             wr_ff, rd_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign push_full = count_ff == 2'd2;
   assign pop_valid = count_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ff];
   assign do_push   = push_valid & ~push_full;
   assign do_pop    = pop_take & pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (do_push) wr_ff <= ~wr_ff;
         if (do_pop) rd_ff <= ~rd_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/gda_back.sv =====
// Back stage: serial day number, offset add, split into 400- and 4-year
// cycles by reciprocal multiplies with one correction step each and into
// 100- and 1-year cycles by compares, then month search. Depends on gda_pkg.
`timescale 1ns / 1ps
module gda_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_take,
   input  gda_pkg::req_type pop_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gda_pkg::rsp_type rsp_data
);

   localparam int SW = gda_pkg::SER_W;
   localparam int YW = gda_pkg::YEAR_W;
   localparam int EW = gda_pkg::EY_W;

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_YDIV   = 14'b00000000000010,
      ST_YREM   = 14'b00000000000100,
      ST_SER1   = 14'b00000000001000,
      ST_SER2   = 14'b00000000010000,
      ST_QEST   = 14'b00000000100000,
      ST_R400   = 14'b00000001000000,
      ST_FIX400 = 14'b00000010000000,
      ST_SPLIT  = 14'b00000100000000,
      ST_Q4E    = 14'b00001000000000,
      ST_R4     = 14'b00010000000000,
      ST_FIX4   = 14'b00100000000000,
      ST_FIN    = 14'b01000000000000,
      ST_MON    = 14'b10000000000000
   } state_type;

   state_type        state_ff, state_in;
   gda_pkg::req_type item_ff;
   logic [32:0]      yprod;
   logic [9:0]       yq_ff;
   logic [YW-1:0]    yrem_ff;
   logic [SW-1:0]    dby_ff, serial, serial_ff;
   logic [8:0]       tab_ff;
   logic [35:0]      sprod;
   logic [9:0]       q400e_ff, q400_ff;
   logic [18:0]      r400w_ff;
   logic [17:0]      r400_ff, r2;
   logic [1:0]       q100_ff, q100;
   logic [15:0]      r2_ff;
   logic [20:0]      qprod;
   logic [4:0]       q4e_ff, q4_ff;
   logic [11:0]      r4w_ff;
   logic [10:0]      rr_ff;
   logic [1:0]       q1;
   logic [8:0]       doy_ff;
   logic [EW-1:0]    ey_ff;
   logic             leap_e_ff;
   logic [YW-1:0]    yr, ny, n100;
   logic             leap_s, out_free;
   logic [SW-1:0]    mul;
   logic [3:0]       em;
   logic [8:0]       mbase;
   logic             rsp_valid_ff;
   gda_pkg::rsp_type rsp_ff;

   assign pop_take = state_ff == ST_IDLE;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // year / 100 is exact for every 16-bit year with this reciprocal
   assign yr     = item_ff.start_year;
   assign yprod  = 33'(yr) * 33'd83887;
   assign ny     = yr - YW'(1);
   assign n100   = (yrem_ff == '0) ? YW'(yq_ff) - YW'(1) : YW'(yq_ff);
   assign leap_s = (yrem_ff == '0) ? (yq_ff[1:0] == 2'd0) : (yr[1:0] == 2'd0);
   assign mul    = SW'(ny) * SW'(365);
   assign serial = dby_ff + SW'(tab_ff) + SW'(item_ff.start_day - 5'd1)
                   + SW'(item_ff.offset_days);

   // estimates are low by at most one; the FIX states correct them
   assign sprod = 36'(serial_ff) * 36'd459;
   assign qprod = 21'(r2_ff) * 21'd44;

   always_comb begin
      if (r400_ff >= 18'd109572) q100 = 2'd3;
      else if (r400_ff >= 18'd73048) q100 = 2'd2;
      else if (r400_ff >= 18'd36524) q100 = 2'd1;
      else q100 = 2'd0;
      r2 = r400_ff - 18'(q100) * 18'd36524;
   end

   always_comb begin
      if (rr_ff >= 11'd1095) q1 = 2'd3;
      else if (rr_ff >= 11'd730) q1 = 2'd2;
      else if (rr_ff >= 11'd365) q1 = 2'd1;
      else q1 = 2'd0;
   end

   always_comb begin
      em = 4'd1;
      for (int i = 1; i < 12; i++) begin
         if (doy_ff >= (leap_e_ff ? gda_pkg::CUM_LEAP[i] : gda_pkg::CUM_COMMON[i]))
            em = 4'(i + 1);
      end
      mbase = leap_e_ff ? gda_pkg::CUM_LEAP[em - 4'd1] : gda_pkg::CUM_COMMON[em - 4'd1];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) state_in = ST_YDIV;
         end
         ST_YDIV:   state_in = ST_YREM;
         ST_YREM:   state_in = ST_SER1;
         ST_SER1:   state_in = ST_SER2;
         ST_SER2:   state_in = ST_QEST;
         ST_QEST:   state_in = ST_R400;
         ST_R400:   state_in = ST_FIX400;
         ST_FIX400: state_in = ST_SPLIT;
         ST_SPLIT:  state_in = ST_Q4E;
         ST_Q4E:    state_in = ST_R4;
         ST_R4:     state_in = ST_FIX4;
         ST_FIX4:   state_in = ST_FIN;
         ST_FIN:    state_in = ST_MON;
         ST_MON: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_MON && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_IDLE && pop_valid) item_ff <= pop_data;
      if (state_ff == ST_YDIV) yq_ff <= yprod[32:23];
      if (state_ff == ST_YREM) yrem_ff <= yr - YW'(yq_ff) * YW'(100);
      if (state_ff == ST_SER1) begin
         dby_ff <= mul + SW'(ny >> 2) - SW'(n100) + SW'(n100 >> 2);
         tab_ff <= leap_s ? gda_pkg::CUM_LEAP[item_ff.start_month - 4'd1]
                          : gda_pkg::CUM_COMMON[item_ff.start_month - 4'd1];
      end
      if (state_ff == ST_SER2) serial_ff <= serial;
      if (state_ff == ST_QEST) q400e_ff <= sprod[35:26];
      if (state_ff == ST_R400) begin
         r400w_ff <= 19'(serial_ff - SW'(q400e_ff) * SW'(146097));
      end
      if (state_ff == ST_FIX400) begin
         if (r400w_ff >= 19'd146097) begin
            q400_ff <= q400e_ff + 10'd1;
            r400_ff <= 18'(r400w_ff - 19'd146097);
         end else begin
            q400_ff <= q400e_ff;
            r400_ff <= r400w_ff[17:0];
         end
      end
      if (state_ff == ST_SPLIT) begin
         q100_ff <= q100;
         r2_ff   <= r2[15:0];
      end
      if (state_ff == ST_Q4E) q4e_ff <= qprod[20:16];
      if (state_ff == ST_R4) r4w_ff <= 12'(r2_ff - 16'(q4e_ff) * 16'd1461);
      if (state_ff == ST_FIX4) begin
         if (r4w_ff >= 12'd1461) begin
            q4_ff <= q4e_ff + 5'd1;
            rr_ff <= 11'(r4w_ff - 12'd1461);
         end else begin
            q4_ff <= q4e_ff;
            rr_ff <= r4w_ff[10:0];
         end
      end
      if (state_ff == ST_FIN) begin
         doy_ff    <= 9'(rr_ff - 11'(q1) * 11'd365);
         ey_ff     <= EW'(q400_ff) * EW'(400) + EW'(q100_ff) * EW'(100)
                      + EW'({q4_ff, 2'b00}) + EW'(q1) + EW'(1);
         leap_e_ff <= (q1 == 2'd3) && ((q4_ff != 5'd24) || (q100_ff == 2'd3));
      end
      if (state_ff == ST_MON && out_free) begin
         if (ey_ff > EW'({YW{1'b1}})) begin
            rsp_ff.end_day   <= 5'd31;
            rsp_ff.end_month <= 4'd12;
            rsp_ff.end_year  <= '1;
            rsp_ff.overflow  <= 1'b1;
         end else begin
            rsp_ff.end_day   <= 5'(doy_ff - mbase + 9'd1);
            rsp_ff.end_month <= em;
            rsp_ff.end_year  <= ey_ff[YW-1:0];
            rsp_ff.overflow  <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/gregorian_date_add_days_top.sv =====
// Top level of the Gregorian date adder: front, queue and back stages.
// Depends on gda_pkg, gda_front, gda_queue and gda_back.
//
// Usage: present a request (offset_days, start_day, start_month, start_year)
// on req_data with req_valid; it is taken at a clock edge where req_stall is
// low. A zero day, month or year becomes 1, a month above 12 becomes 12.
// One response per request appears on rsp_data with rsp_valid and is taken
// when rsp_stall is low; responses keep request order.
// A request passes through the front register and a queue entry, then the
// back stage walks 13 steps (year split, serial day number, splits into
// 400- and 4-year cycles by reciprocal multiplies with one correction each
// and into 100- and 1-year cycles by compares, month search). It takes a
// new request only after the last one is done. Two requests can wait in the
// queue and one in the front stage while the back stage works.
// A stalled response holds; the back stage finishes its next request and
// waits with it, then the queue and front fill and req_stall rises.
// Reset empties all stages and drops rsp_valid.
`timescale 1ns / 1ps
module gregorian_date_add_days_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gda_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gda_pkg::rsp_type rsp_data
);

   logic             push_valid, push_full, pop_valid, pop_take;
   gda_pkg::req_type push_data, pop_data;

   gda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data)
   );

   gda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_take   (pop_take),
      .pop_data   (pop_data)
   );

   gda_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_take  (pop_take),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.end_day == 5'd31 && rsp_data.end_month == 4'd12 &&
         rsp_data.end_year == '1)
      else $error("overflow response not saturated");

   a_date_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.overflow |->
         rsp_data.end_month >= 4'd1 && rsp_data.end_month <= 4'd12 &&
         rsp_data.end_day >= 5'd1 && rsp_data.end_year != '0)
      else $error("response date out of range");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> push_full && push_valid)
      else $error("request stalled without a full queue");
`endif

endmodule
